>>> rtl/core/msps_pkg.sv
// ----------------------------------------------------------------------------
// msps_pkg
// shared types, codes and helpers of the multi stepper position sequencer
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int unsigned MotorsDef  = 4;
  localparam int unsigned NumEntries = 4;
  localparam int unsigned MotorIdxW  = 2;
  localparam int unsigned PosW       = 16;
  localparam int unsigned SpanW      = 14;
  localparam int unsigned CountW     = 15;
  localparam int unsigned MotorCntW  = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 14;
  localparam int unsigned CoilW      = 4;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_SET_TARGET   = 2'd1,
    OP_START_HOMING = 2'd2,
    OP_UNUSED       = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_MOTOR_COUNT = 3'd0,
    REG_SPAN_A      = 3'd1,
    REG_SPAN_B      = 3'd2,
    REG_SPAN_C      = 3'd3,
    REG_SPAN_D      = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // one motor's entry in the state memory
  typedef struct packed {
    logic [CountW-1:0]      homing_count;
    logic                   homing_flag;
    logic signed [PosW-1:0] target;
    logic signed [PosW-1:0] position;
  } entry_t;

  // memory write request
  typedef struct packed {
    logic                 en;
    logic [MotorIdxW-1:0] addr;
    entry_t               data;
  } mem_wr_t;

  // wave drive: position mod 4 of 1,2,3,0 drives coil 1,2,3,4
  function automatic logic [CoilW-1:0] coils_for(input logic [PosW-1:0] pos);
    logic [1:0] phase;
    phase = pos[1:0] + 2'd3;
    return 4'b0001 << phase;
  endfunction

endpackage

>>> rtl/core/multi_stepper_position_sequencer_top.sv
// ----------------------------------------------------------------------------
// multi_stepper_position_sequencer_top
// time shared wave drive sequencer with homing for up to four steppers
// ----------------------------------------------------------------------------
// usage:
//   commands enter on the s_axis channel: tuser carries the opcode (tick,
//   set target, start homing), tdata the motor select and signed target.
//   every tick serves the next motor in round robin and yields one word on
//   m_axis with the served motor, coil pattern, position and homing flag;
//   set target and start homing only update state and give no word.
//   configuration (motor count, per motor spans) is written on cfg_* while
//   the block is idle, one register per cycle at cfg_we_i.
// timing:
//   per motor state sits in a small memory with a registered read, so each
//   command does a read, then a modify and write back. the unused opcode
//   is dropped without a read and gives no word. a tick word appears on
//   m_axis the cycle after the write back.
// reset and stall:
//   reset clears motor count to one, spans to zero and all motor entries to
//   zero through valid bits, no clearing pass. a stalled m_axis word sits in
//   the output register; set target and start homing keep flowing, and the
//   next tick is taken but waits in the write back step until the output
//   register frees up.
// ----------------------------------------------------------------------------
module multi_stepper_position_sequencer_top #(
  parameter int unsigned MOTORS = msps_pkg::MotorsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [23:0]                       s_axis_tdata_i,  // motor_select[1:0], target[17:2]
  input  logic [1:0]                        s_axis_tuser_i,  // opcode[1:0]
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // motor_served[1:0], coil_pattern[5:2], position[21:6], homing[22]
  output logic [23:0]                       m_axis_tdata_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [msps_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [msps_pkg::CfgDataW-1:0]     cfg_data_i
);
  import msps_pkg::*;

  // configuration registers
  logic [MotorCntW-1:0] motor_count_q;
  logic [SpanW-1:0]     span_q [NumEntries];

  // sequencer state
  state_e               state_q, state_d;
  logic [MotorIdxW-1:0] next_motor_q, next_motor_d;
  opcode_e              op_q;
  logic [MotorIdxW-1:0] addr_q;
  logic signed [PosW-1:0] target_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [MotorIdxW-1:0] out_motor_q;
  logic [CoilW-1:0]     out_coils_q;
  logic [PosW-1:0]      out_pos_q;
  logic                 out_homing_q;

  logic                 in_accept;
  opcode_e              in_op;
  logic [MotorIdxW-1:0] in_sel;
  logic [MotorCntW-1:0] active_cnt;
  logic [MotorIdxW-1:0] served;
  logic                 rd_en;
  logic [MotorIdxW-1:0] rd_addr;
  entry_t               rd_entry;
  entry_t               new_entry;
  logic [CoilW-1:0]     new_coils;
  mem_wr_t              mem_wr;
  logic                 out_stall;
  logic                 out_load;

  assign in_op     = opcode_e'(s_axis_tuser_i);
  assign in_sel    = s_axis_tdata_i[1:0];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // count zero acts as one, above the motor limit as the limit
  always_comb begin
    if (motor_count_q == '0) begin
      active_cnt = MotorCntW'(1);
    end else if (motor_count_q > MotorCntW'(MOTORS)) begin
      active_cnt = MotorCntW'(MOTORS);
    end else begin
      active_cnt = motor_count_q;
    end
  end

  // pointer past the count falls back to motor 0
  assign served  = ({1'b0, next_motor_q} < active_cnt) ? next_motor_q : '0;
  assign rd_en   = in_accept && (in_op != OP_UNUSED);
  assign rd_addr = (in_op == OP_TICK) ? served : in_sel;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_count_q <= MotorCntW'(1);
      for (int i = 0; i < NumEntries; i++) begin
        span_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MOTOR_COUNT: motor_count_q <= cfg_data_i[MotorCntW-1:0];
        REG_SPAN_A:      span_q[0]     <= cfg_data_i;
        REG_SPAN_B:      span_q[1]     <= cfg_data_i;
        REG_SPAN_C:      span_q[2]     <= cfg_data_i;
        REG_SPAN_D:      span_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  msps_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry),
    .wr_i      (mem_wr)
  );

  msps_step u_step (
    .op_i     (op_q),
    .target_i (target_q),
    .span_i   (span_q[addr_q]),
    .entry_i  (rd_entry),
    .entry_o  (new_entry),
    .coils_o  (new_coils)
  );

  // a tick may only write back once its word has a place to go
  assign out_stall = out_valid_q && !m_axis_tready_i;

  always_comb begin
    state_d         = state_q;
    next_motor_d    = next_motor_q;
    s_axis_tready_o = 1'b0;
    mem_wr.en       = 1'b0;
    mem_wr.addr     = addr_q;
    mem_wr.data     = new_entry;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // ready is always high here, so valid alone marks the accept
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && (in_op != OP_UNUSED)) begin
          state_d = ST_EXEC;
          if (in_op == OP_TICK) begin
            next_motor_d = served + 2'd1;
          end
        end
      end
      ST_EXEC: begin
        if (op_q != OP_TICK) begin
          mem_wr.en = 1'b1;
          state_d   = ST_IDLE;
        end else if (!out_stall) begin
          mem_wr.en = 1'b1;
          out_load  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      next_motor_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_motor_q <= next_motor_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_op;
      addr_q   <= rd_addr;
      target_q <= s_axis_tdata_i[17:2];
    end
    if (out_load) begin
      out_motor_q  <= addr_q;
      out_coils_q  <= new_coils;
      out_pos_q    <= new_entry.position;
      out_homing_q <= new_entry.homing_flag;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_homing_q, out_pos_q, out_coils_q, out_motor_q};

`ifndef SYNTH
  // wave drive never lights more than one coil
  a_coils_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(out_coils_q))
    else $error("coil pattern drives more than one coil");

  // a new result word only comes out of the write back step
  a_word_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result word loaded outside write back");

  // a write back never overwrites a waiting result word
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && !m_axis_tready_i))
    else $error("result word overwritten while stalled");
`endif

endmodule

>>> rtl/core/msps_mem.sv
// ----------------------------------------------------------------------------
// msps_mem
// motor state memory, one write and one registered read port, valid bits
// ----------------------------------------------------------------------------
module msps_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [msps_pkg::MotorIdxW-1:0]  rd_addr_i,
  output msps_pkg::entry_t                rd_data_o,
  input  msps_pkg::mem_wr_t               wr_i
);
  import msps_pkg::*;

  entry_t                mem [NumEntries];
  logic [NumEntries-1:0] valid_q;
  entry_t                rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never written entries read as the reset value
  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

>>> rtl/core/msps_step.sv
// ----------------------------------------------------------------------------
// msps_step
// modify stage: applies one command to a motor entry
// ----------------------------------------------------------------------------
module msps_step (
  input  msps_pkg::opcode_e               op_i,
  input  logic signed [msps_pkg::PosW-1:0] target_i,
  input  logic [msps_pkg::SpanW-1:0]      span_i,
  input  msps_pkg::entry_t                entry_i,
  output msps_pkg::entry_t                entry_o,
  output logic [msps_pkg::CoilW-1:0]      coils_o
);
  import msps_pkg::*;

  logic signed [PosW:0]   half_s;
  logic signed [PosW:0]   neg_half_s;
  logic signed [PosW:0]   tgt_s;
  logic [CountW-1:0]      back_end;
  logic [CountW-1:0]      fwd_end;
  logic signed [PosW-1:0] pos_up;
  logic signed [PosW-1:0] pos_dn;
  logic [CountW-1:0]      cnt_inc;

  assign half_s     = {4'b0000, span_i[SpanW-1:1]};
  assign neg_half_s = -half_s;
  assign tgt_s      = {target_i[PosW-1], target_i};
  assign back_end   = {1'b0, span_i};
  assign fwd_end    = {1'b0, span_i} + {2'b00, span_i[SpanW-1:1]};
  assign pos_up     = entry_i.position + 16'sd1;
  assign pos_dn     = entry_i.position - 16'sd1;
  assign cnt_inc    = entry_i.homing_count + 15'd1;

  always_comb begin
    entry_o = entry_i;
    coils_o = '0;
    case (op_i)
      OP_SET_TARGET: begin
        if (tgt_s > half_s) begin
          entry_o.target = half_s[PosW-1:0];
        end else if (tgt_s < neg_half_s) begin
          entry_o.target = neg_half_s[PosW-1:0];
        end else begin
          entry_o.target = target_i;
        end
      end
      OP_START_HOMING: begin
        entry_o.homing_flag  = 1'b1;
        entry_o.homing_count = '0;
      end
      OP_TICK: begin
        if (entry_i.homing_flag) begin
          if (entry_i.homing_count < back_end) begin
            entry_o.position     = pos_dn;
            entry_o.homing_count = cnt_inc;
            coils_o              = coils_for(pos_dn);
          end else if (entry_i.homing_count < fwd_end) begin
            entry_o.position     = pos_up;
            entry_o.homing_count = cnt_inc;
            coils_o              = coils_for(pos_up);
          end else begin
            entry_o.position    = '0;
            entry_o.homing_flag = 1'b0;
          end
        end else if (entry_i.target > entry_i.position) begin
          entry_o.position = pos_up;
          coils_o          = coils_for(pos_up);
        end else if (entry_i.target < entry_i.position) begin
          entry_o.position = pos_dn;
          coils_o          = coils_for(pos_dn);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sim/tb_multi_stepper_position_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_stepper_position_sequencer_top
// self-checking bench for the time shared stepper sequencer with homing
// ----------------------------------------------------------------------------
// commands go in on s_axis and every accepted one updates a local copy of
// the motor table. ticks also queue the word that the block must return.
// m_axis words are compared field by field with the oldest queued word.
// the run does a short directed part, then random phases over several
// motor counts and span settings with different sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_multi_stepper_position_sequencer_top;
  import msps_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned NumPhases    = 12;

  // expected m_axis word, packed like tdata from the lowest bit up
  typedef struct packed {
    logic        homing;
    logic [15:0] position;
    logic [3:0]  coils;
    logic [1:0]  motor;
  } motor_word_t;

  // local copy of the motor table plus the queue of words still owed
  class sequencer_scoreboard;
    logic [2:0]         motor_count = 3'd1;
    logic [13:0]        span [4]    = '{default: '0};
    logic [1:0]         next_motor  = '0;
    logic signed [15:0] cur_pos [4] = '{default: '0};
    logic signed [15:0] tgt_pos [4] = '{default: '0};
    logic               hflag [4]   = '{default: '0};
    logic [14:0]        hcount [4]  = '{default: '0};
    motor_word_t        pending_words [$];
    int                 mismatch_count = 0;

    function void write_reg(cfg_reg_e idx, logic [13:0] value);
      case (idx)
        REG_MOTOR_COUNT: motor_count = value[2:0];
        REG_SPAN_A:      span[0] = value;
        REG_SPAN_B:      span[1] = value;
        REG_SPAN_C:      span[2] = value;
        REG_SPAN_D:      span[3] = value;
        default: ;
      endcase
    endfunction

    // one-hot wave drive: phase 1,2,3,0 lights coil 1,2,3,4
    function logic [3:0] wave_coils(logic [15:0] pos);
      case (pos[1:0])
        2'd1:    return 4'b0001;
        2'd2:    return 4'b0010;
        2'd3:    return 4'b0100;
        default: return 4'b1000;
      endcase
    endfunction

    function motor_word_t serve_next_motor();
      motor_word_t        w;
      int                 active, span_i, cnt_i;
      logic [1:0]         m;
      logic signed [15:0] pos;
      logic [3:0]         coils;
      active = (motor_count == 0) ? 1 :
               (motor_count > MotorsDef) ? MotorsDef : motor_count;
      m = next_motor;
      if (m >= active) m = 2'd0;
      next_motor = m + 2'd1;
      span_i = span[m];
      cnt_i  = hcount[m];
      pos    = cur_pos[m];
      if (hflag[m]) begin
        if (cnt_i < span_i) begin
          pos = pos - 16'sd1;
          hcount[m] = hcount[m] + 15'd1;
          coils = wave_coils(pos);
        end else if (cnt_i < span_i + (span_i >> 1)) begin
          pos = pos + 16'sd1;
          hcount[m] = hcount[m] + 15'd1;
          coils = wave_coils(pos);
        end else begin
          pos = '0;
          hflag[m] = 1'b0;
          coils = '0;
        end
      end else if (pos == tgt_pos[m]) begin
        coils = '0;
      end else begin
        if (tgt_pos[m] > pos) pos = pos + 16'sd1;
        else pos = pos - 16'sd1;
        coils = wave_coils(pos);
      end
      cur_pos[m] = pos;
      w.motor    = m;
      w.coils    = coils;
      w.position = pos;
      w.homing   = hflag[m];
      return w;
    endfunction

    function void note_command(opcode_e op, logic [1:0] sel, logic [15:0] tgt);
      int t, half;
      case (op)
        OP_SET_TARGET: begin
          t    = $signed(tgt);
          half = span[sel] >> 1;
          if (t > half) t = half;
          if (t < -half) t = -half;
          tgt_pos[sel] = t[15:0];
        end
        OP_START_HOMING: begin
          hflag[sel]  = 1'b1;
          hcount[sel] = '0;
        end
        OP_TICK: pending_words.push_back(serve_next_motor());
        default: ;
      endcase
    endfunction

    function void check_word(logic [23:0] word);
      motor_word_t got, want;
      got = word[22:0];
      if (pending_words.size() == 0) begin
        $error("unexpected word %h", word);
        mismatch_count++;
        return;
      end
      want = pending_words.pop_front();
      if (got.motor !== want.motor) begin
        $error("motor_served: expected %0d, got %0d", want.motor, got.motor);
        mismatch_count++;
      end
      if (got.coils !== want.coils) begin
        $error("coil_pattern: expected %b, got %b", want.coils, got.coils);
        mismatch_count++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d",
               $signed(want.position), $signed(got.position));
        mismatch_count++;
      end
      if (got.homing !== want.homing) begin
        $error("homing: expected %b, got %b", want.homing, got.homing);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_index_i     = '0;
  logic [13:0] cfg_data_i      = '0;

  sequencer_scoreboard sb = new();

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  multi_stepper_position_sequencer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // motor_select[1:0], target[17:2]
    .s_axis_tuser_i (s_axis_tuser_i),   // opcode[1:0]
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // motor[1:0], coils[5:2], pos[21:6], homing[22]
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: random back pressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor: every accepted word is checked against the queue
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one command word, with random gaps ahead of it
  task automatic drive_command(input opcode_e op, input logic [1:0] sel,
                               input logic [15:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'd0, tgt, sel};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    sb.note_command(op, sel, tgt);
    @(negedge clk_i);
  endtask

  // hold the sender until every owed word is back, then idle a little more
  task automatic settle(input int unsigned extra_cycles);
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (extra_cycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [13:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  // block must be idle here
  task automatic load_config(input logic [2:0] count, input logic [13:0] s0,
                             input logic [13:0] s1, input logic [13:0] s2,
                             input logic [13:0] s3);
    write_reg(REG_MOTOR_COUNT, {11'd0, count});
    write_reg(REG_SPAN_A, s0);
    write_reg(REG_SPAN_B, s1);
    write_reg(REG_SPAN_C, s2);
    write_reg(REG_SPAN_D, s3);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
      3:       begin send_idle_pct = 10; recv_stall_pct = 10; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // random phase: mostly target-then-ticks and homing-then-ticks runs,
  // with some noise words (unused opcode included) mixed in
  task automatic run_phase(input int n_items, input int active, input int max_span);
    int          done, kind, n_ticks, small_t, i;
    logic [1:0]  m;
    logic [15:0] t;
    opcode_e     op;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 99);
      m    = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) == 0) settle(0);
      if (kind < 55) begin
        if ($urandom_range(0, 1) == 1) begin
          t = 16'($urandom_range(0, 65535));
        end else begin
          small_t = int'($urandom_range(0, 40)) - 20;
          t = small_t[15:0];
        end
        n_ticks = $urandom_range(1, 4 * active + 4);
        drive_command(OP_SET_TARGET, m, t);
        for (i = 0; i < n_ticks; i++)
          drive_command(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        done += 1 + n_ticks;
      end else if (kind < 75) begin
        // up to enough ticks to finish homing on small spans, capped on big ones
        n_ticks = (max_span * 3 / 2 + 2) * active;
        if (n_ticks > 80) n_ticks = 80;
        n_ticks = $urandom_range(n_ticks / 2, n_ticks);
        drive_command(OP_START_HOMING, m, 16'($urandom_range(0, 65535)));
        for (i = 0; i < n_ticks; i++)
          drive_command(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        done += 1 + n_ticks;
      end else begin
        n_ticks = $urandom_range(1, 6);
        for (i = 0; i < n_ticks; i++) begin
          op = opcode_e'($urandom_range(0, 3));
          drive_command(op, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
          if (op != OP_UNUSED) done++;
        end
      end
    end
  endtask

  initial begin
    int          phase_counts [NumPhases];
    logic [13:0] sp [4];
    int          p, k, act, mx, pick;

    phase_counts = '{4, 2, 0, 7, 3, 1, 4, 5, 2, 4, 6, 3};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, one motor, zero spans
    drive_command(OP_TICK, 2'd2, 16'h1234);
    drive_command(OP_SET_TARGET, 2'd0, 16'h7fff);   // clamps to zero
    drive_command(OP_SET_TARGET, 2'd0, 16'h8000);
    drive_command(OP_START_HOMING, 2'd0, 16'h0000);
    drive_command(OP_TICK, 2'd0, 16'h0000);         // zero span homing ends at once
    drive_command(OP_UNUSED, 2'd3, 16'hffff);       // dropped, no word
    drive_command(OP_SET_TARGET, 2'd3, 16'd100);    // motor outside the count
    drive_command(OP_START_HOMING, 2'd2, 16'h0000);
    drive_command(OP_TICK, 2'd1, 16'h0000);
    settle(SettleCycles);

    // directed: four motors, extreme and small spans
    load_config(3'd4, 14'h3fff, 14'd6, 14'd1, 14'd0);
    drive_command(OP_SET_TARGET, 2'd0, 16'h7fff);   // clamps to +8191
    drive_command(OP_SET_TARGET, 2'd1, 16'h8000);   // clamps to -3
    drive_command(OP_SET_TARGET, 2'd2, 16'h5555);   // clamps to zero
    drive_command(OP_START_HOMING, 2'd1, 16'h0000);
    drive_command(OP_START_HOMING, 2'd3, 16'h0000);
    for (k = 0; k < 10; k++) drive_command(OP_TICK, 2'(k), 16'h0000);
    drive_command(OP_UNUSED, 2'd0, 16'h0000);
    settle(SettleCycles);

    // random phases, each with its own count, spans and idling
    for (p = 0; p < NumPhases; p++) begin
      mx = 0;
      for (k = 0; k < 4; k++) begin
        pick = $urandom_range(0, 7);
        if (p == 3) sp[k] = 14'h3fff;
        else if (p == 5) sp[k] = '0;
        else if (pick == 0) sp[k] = 14'h3fff;
        else if (pick == 1) sp[k] = '0;
        else sp[k] = 14'($urandom_range(0, 24));
        if (sp[k] > mx) mx = sp[k];
      end
      load_config(3'(phase_counts[p]), sp[0], sp[1], sp[2], sp[3]);
      act = (phase_counts[p] == 0) ? 1 :
            (phase_counts[p] > MotorsDef) ? MotorsDef : phase_counts[p];
      set_idle(p % 4);
      run_phase(PhaseItems, act, mx);
      settle(SettleCycles);
    end

    set_idle(0);
    settle(SettleCycles);
    if (sb.mismatch_count == 0 && sb.pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
